>>> design/fbvs_pkg.sv
// Shared types, constants and helpers for the four-bone vertex skinning block.
// Used by fbvs_palette, fbvs_seq, fbvs_dp and four_bone_vertex_skinning.
package fbvs_pkg;

    localparam int WORD_W         = 32;
    localparam int WEIGHT_W       = 17;
    localparam int ADDR_W         = 10;
    localparam int JOINT_W        = 8;
    localparam int NUM_INF        = 4;
    localparam int COLS           = 4;
    localparam int COL_W          = 2;
    localparam int ROWS_PER_BONE  = 3;
    localparam int WORDS_PER_BONE = 12;
    localparam int FRAC_W         = 16;
    localparam int PROD_W         = 64;
    localparam int TW_W           = WORD_W + WEIGHT_W + 1;
    localparam int ACC_W          = 51;

    localparam logic [WEIGHT_W-1:0] THR_RESET = 17'd66;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SKIN  = 1'b1;

    localparam logic [1:0] LAST_INF   = 2'd3;
    localparam logic [1:0] LAST_ROW   = 2'd2;
    // four datapath stages behind the palette read
    localparam logic [1:0] DRAIN_LOAD = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } t_seq_state;

    // one matrix row: columns 0..2 rotate/scale, column 3 translates
    typedef logic [COLS-1:0][WORD_W-1:0] t_row;

    typedef struct packed {
        logic                en;
        logic [1:0]          row;
        logic [WEIGHT_W-1:0] weight;
    } t_slot;

    typedef struct packed {
        logic  clear;
        logic  finish;
        t_slot slot;
    } t_seq_cmd;

    // Clamp a wide signed value to a signed 32-bit word.
    function automatic logic [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-WORD_W:0] hi;
        logic [WORD_W-1:0]     res;
        hi = v[ACC_W-1:WORD_W-1];
        if (hi == '0 || hi == '1) begin
            res = v[WORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> design/fbvs_palette.sv
// Bone palette memory: one 128-bit matrix row per entry, word-enable writes.
// Synchronous read: the row read is registered. Depends on fbvs_pkg.
module fbvs_palette #(
    parameter int  MAX_BONES = 64,
    localparam int DEPTH     = MAX_BONES * fbvs_pkg::ROWS_PER_BONE,
    localparam int ROW_AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ROW_AW-1:0]             i_wr_row,
    input  logic [fbvs_pkg::COL_W-1:0]    i_wr_col,
    input  logic [fbvs_pkg::WORD_W-1:0]   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [ROW_AW-1:0]             i_rd_row,
    output fbvs_pkg::t_row                o_rd_data
);

    fbvs_pkg::t_row r_mem [DEPTH];
    fbvs_pkg::t_row r_rd_data;

    // write one word of a row, read a whole row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/fbvs_seq.sv
// Sequencer: input handshake, threshold register, palette write decode and
// the walk over four influences by three rows. Depends on fbvs_pkg.
module fbvs_seq #(
    parameter int  MAX_BONES = 64,
    localparam int DEPTH     = MAX_BONES * fbvs_pkg::ROWS_PER_BONE,
    localparam int ROW_AW    = $clog2(DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [fbvs_pkg::ADDR_W-1:0]     i_palette_address,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_a,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_b,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_c,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_d,
    input  logic [fbvs_pkg::WORD_W-1:0]     i_joint_indices,
    input  logic                            i_out_free,
    output logic                            o_wr_en,
    output logic [ROW_AW-1:0]               o_wr_row,
    output logic [fbvs_pkg::COL_W-1:0]      o_wr_col,
    output logic                            o_rd_en,
    output logic [ROW_AW-1:0]               o_rd_row,
    output fbvs_pkg::t_seq_cmd              o_cmd
);

    localparam int PAL_WORDS = MAX_BONES * fbvs_pkg::WORDS_PER_BONE;
    localparam int CMP_W     = ($clog2(PAL_WORDS + 1) > fbvs_pkg::ADDR_W) ?
                               $clog2(PAL_WORDS + 1) : fbvs_pkg::ADDR_W;
    localparam int BONE_CW   = fbvs_pkg::JOINT_W + 1;

    fbvs_pkg::t_seq_state              r_state, n_state;
    logic [1:0]                        r_inf, n_inf;
    logic [1:0]                        r_row, n_row;
    logic [1:0]                        r_drain, n_drain;
    logic [fbvs_pkg::WEIGHT_W-1:0]     r_thr;
    logic [fbvs_pkg::WEIGHT_W-1:0]     r_wt [fbvs_pkg::NUM_INF];
    logic [fbvs_pkg::WORD_W-1:0]       r_joint;

    logic                              accept;
    logic                              skin_start;
    logic [fbvs_pkg::WEIGHT_W-1:0]     sel_weight;
    logic [fbvs_pkg::JOINT_W-1:0]      sel_bone;
    logic                              bone_ok;
    logic                              slot_en;
    logic [fbvs_pkg::ADDR_W-1:0]       rd_full;
    logic [fbvs_pkg::ADDR_W-1:0]       wr_full;
    logic                              finish;

    assign accept     = i_valid && o_ready;
    assign skin_start = accept && (i_func == fbvs_pkg::FUNC_SKIN);

    // decode palette word writes; drop those beyond the palette
    assign wr_full  = fbvs_pkg::ADDR_W'(i_palette_address[fbvs_pkg::ADDR_W-1:fbvs_pkg::COL_W]);
    assign o_wr_row = wr_full[ROW_AW-1:0];
    assign o_wr_col = i_palette_address[fbvs_pkg::COL_W-1:0];
    assign o_wr_en  = accept && (i_func == fbvs_pkg::FUNC_WRITE) &&
                      (CMP_W'(i_palette_address) < CMP_W'(PAL_WORDS));

    // select the current influence and its palette row
    assign sel_weight = r_wt[r_inf];
    assign sel_bone   = r_joint[{r_inf, 3'b000} +: fbvs_pkg::JOINT_W];
    assign bone_ok    = (BONE_CW'(sel_bone) < BONE_CW'(MAX_BONES));
    assign slot_en    = (r_state == fbvs_pkg::ST_ISSUE) && bone_ok && (sel_weight > r_thr);
    assign rd_full    = fbvs_pkg::ADDR_W'(sel_bone) *
                        fbvs_pkg::ADDR_W'(fbvs_pkg::ROWS_PER_BONE) +
                        fbvs_pkg::ADDR_W'(r_row);
    assign o_rd_row   = bone_ok ? rd_full[ROW_AW-1:0] : '0;

    assign o_cmd.clear       = skin_start;
    assign o_cmd.finish      = finish;
    assign o_cmd.slot.en     = slot_en;
    assign o_cmd.slot.row    = r_row;
    assign o_cmd.slot.weight = sel_weight;

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_inf   = r_inf;
        n_row   = r_row;
        n_drain = r_drain;
        o_ready = 1'b0;
        o_rd_en = 1'b0;
        finish  = 1'b0;
        case (r_state)
            fbvs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_func == fbvs_pkg::FUNC_SKIN) begin
                    n_state = fbvs_pkg::ST_ISSUE;
                    n_inf   = '0;
                    n_row   = '0;
                end
            end
            fbvs_pkg::ST_ISSUE: begin
                o_rd_en = slot_en;
                if (r_row == fbvs_pkg::LAST_ROW) begin
                    n_row = '0;
                    if (r_inf == fbvs_pkg::LAST_INF) begin
                        n_state = fbvs_pkg::ST_DRAIN;
                        n_drain = fbvs_pkg::DRAIN_LOAD;
                    end else begin
                        n_inf = r_inf + 2'd1;
                    end
                end else begin
                    n_row = r_row + 2'd1;
                end
            end
            fbvs_pkg::ST_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = fbvs_pkg::ST_FINISH;
                end else begin
                    n_drain = r_drain - 2'd1;
                end
            end
            fbvs_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    finish  = 1'b1;
                    n_state = fbvs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fbvs_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbvs_pkg::ST_IDLE;
            r_inf   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_inf   <= n_inf;
            r_row   <= n_row;
            r_drain <= n_drain;
        end
    end

    // hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= fbvs_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // capture weights and bone indices of a skin beat
    always_ff @(posedge i_clk) begin
        if (skin_start) begin
            r_wt[0] <= i_weight_a;
            r_wt[1] <= i_weight_b;
            r_wt[2] <= i_weight_c;
            r_wt[3] <= i_weight_d;
            r_joint <= i_joint_indices;
        end
    end

    a_skin_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skin_start |=> (r_state == fbvs_pkg::ST_ISSUE && r_inf == '0 && r_row == '0))
        else $error("skin beat did not start the row walk");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbvs_pkg::ST_ISSUE && r_inf == fbvs_pkg::LAST_INF &&
         r_row == fbvs_pkg::LAST_ROW)
        |=> (r_state == fbvs_pkg::ST_DRAIN && r_drain == fbvs_pkg::DRAIN_LOAD))
        else $error("row walk did not enter drain after the last row");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_out_free)
        else $error("result loaded while output register still full");

    a_read_weighted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (sel_weight > r_thr && bone_ok))
        else $error("palette read for an influence that does not contribute");

endmodule

>>> design/fbvs_dp.sv
// Datapath: row transform (three multiplies, sum, clamp), weight scaling,
// per-axis accumulation and the output register. Depends on fbvs_pkg.
module fbvs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fbvs_pkg::t_seq_cmd              i_cmd,
    input  logic [fbvs_pkg::WORD_W-1:0]     i_pos_x,
    input  logic [fbvs_pkg::WORD_W-1:0]     i_pos_y,
    input  logic [fbvs_pkg::WORD_W-1:0]     i_pos_z,
    input  fbvs_pkg::t_row                  i_rd_data,
    input  logic                            i_out_ready,
    output logic                            o_out_free,
    output logic                            o_valid,
    output logic [fbvs_pkg::WORD_W-1:0]     o_out_x,
    output logic [fbvs_pkg::WORD_W-1:0]     o_out_y,
    output logic [fbvs_pkg::WORD_W-1:0]     o_out_z
);

    fbvs_pkg::t_slot                       r_s1, r_s2, r_s3, r_s4;
    logic signed [fbvs_pkg::WORD_W-1:0]    r_p    [3];
    logic signed [fbvs_pkg::PROD_W-1:0]    r_prod [3];
    logic signed [fbvs_pkg::WORD_W-1:0]    r_m3;
    logic signed [fbvs_pkg::WORD_W-1:0]    r_t;
    logic signed [fbvs_pkg::TW_W-1:0]      r_tw;
    logic signed [fbvs_pkg::ACC_W-1:0]     r_acc  [3];
    logic [fbvs_pkg::WORD_W-1:0]           r_out  [3];
    logic                                  r_out_vld;
    logic signed [fbvs_pkg::ACC_W-1:0]     row_sum;

    // advance slot control alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
        end else begin
            r_s1 <= i_cmd.slot;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
        end
    end

    // hold the vertex position for the whole item
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_p[0] <= i_pos_x;
            r_p[1] <= i_pos_y;
            r_p[2] <= i_pos_z;
        end
    end

    // stage 1: three column products of the row read
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= $signed(i_rd_data[c]) * r_p[c];
        end
        r_m3 <= i_rd_data[3];
    end

    // stage 2: floor each product to Q16.16, add translation, clamp
    assign row_sum = fbvs_pkg::ACC_W'(r_m3) +
                     fbvs_pkg::ACC_W'(r_prod[0] >>> fbvs_pkg::FRAC_W) +
                     fbvs_pkg::ACC_W'(r_prod[1] >>> fbvs_pkg::FRAC_W) +
                     fbvs_pkg::ACC_W'(r_prod[2] >>> fbvs_pkg::FRAC_W);

    always_ff @(posedge i_clk) begin
        r_t <= fbvs_pkg::sat_word(row_sum);
    end

    // stage 3: scale by the influence weight
    always_ff @(posedge i_clk) begin
        r_tw <= r_t * $signed({1'b0, r_s3.weight});
    end

    // stage 4: accumulate into the row's axis
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            if (i_cmd.clear) begin
                r_acc[r] <= '0;
            end else if (r_s4.en && r_s4.row == 2'(r)) begin
                r_acc[r] <= r_acc[r] + fbvs_pkg::ACC_W'(r_tw);
            end
        end
    end

    // load the output register, drop the valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int r = 0; r < 3; r++) begin
                r_out[r] <= fbvs_pkg::sat_word(r_acc[r] >>> fbvs_pkg::FRAC_W);
            end
        end
    end

    assign o_out_free = !r_out_vld || i_out_ready;
    assign o_valid    = r_out_vld;
    assign o_out_x    = r_out[0];
    assign o_out_y    = r_out[1];
    assign o_out_z    = r_out[2];

endmodule

>>> design/four_bone_vertex_skinning.sv
// Four-influence linear blend skinning over a bone matrix palette held in one
// row-wide synchronous memory. Palette write beats are accepted back to back.
// No further beat is accepted while a skin beat runs: it walks twelve palette
// row slots (four influences by three rows, one 128-bit row per cycle from the
// single read port), drains the multiply/sum/scale/accumulate stages and loads
// the output register once it is free. A finished result waits in the output
// register while the next beat is accepted; the next skin result is loaded
// only once the previous one has been taken.
// Depends on fbvs_pkg, fbvs_palette, fbvs_seq and fbvs_dp.
module four_bone_vertex_skinning #(
    parameter int  MAX_BONES = 64,
    localparam int DEPTH     = MAX_BONES * fbvs_pkg::ROWS_PER_BONE,
    localparam int ROW_AW    = $clog2(DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [fbvs_pkg::ADDR_W-1:0]     i_palette_address,
    input  logic signed [fbvs_pkg::WORD_W-1:0] i_palette_word,
    input  logic signed [fbvs_pkg::WORD_W-1:0] i_pos_x,
    input  logic signed [fbvs_pkg::WORD_W-1:0] i_pos_y,
    input  logic signed [fbvs_pkg::WORD_W-1:0] i_pos_z,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_a,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_b,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_c,
    input  logic [fbvs_pkg::WEIGHT_W-1:0]   i_weight_d,
    input  logic [fbvs_pkg::WORD_W-1:0]     i_joint_indices,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [fbvs_pkg::WORD_W-1:0] o_out_x,
    output logic signed [fbvs_pkg::WORD_W-1:0] o_out_y,
    output logic signed [fbvs_pkg::WORD_W-1:0] o_out_z
);

    logic                           wr_en;
    logic [ROW_AW-1:0]              wr_row;
    logic [fbvs_pkg::COL_W-1:0]     wr_col;
    logic                           rd_en;
    logic [ROW_AW-1:0]              rd_row;
    fbvs_pkg::t_row                 rd_data;
    fbvs_pkg::t_seq_cmd             cmd;
    logic                           out_free;

    fbvs_palette #(
        .MAX_BONES (MAX_BONES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_row  (wr_row),
        .i_wr_col  (wr_col),
        .i_wr_data (i_palette_word),
        .i_rd_en   (rd_en),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data)
    );

    fbvs_seq #(
        .MAX_BONES (MAX_BONES)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_palette_address (i_palette_address),
        .i_weight_a        (i_weight_a),
        .i_weight_b        (i_weight_b),
        .i_weight_c        (i_weight_c),
        .i_weight_d        (i_weight_d),
        .i_joint_indices   (i_joint_indices),
        .i_out_free        (out_free),
        .o_wr_en           (wr_en),
        .o_wr_row          (wr_row),
        .o_wr_col          (wr_col),
        .o_rd_en           (rd_en),
        .o_rd_row          (rd_row),
        .o_cmd             (cmd)
    );

    fbvs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_rd_data   (rd_data),
        .i_out_ready (i_ready),
        .o_out_free  (out_free),
        .o_valid     (o_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z)
    );

endmodule
